### rtl/core/touch_autorepeat_clock_control_assert.svh
// assertion macros for the touch auto-repeat clock control block
`ifndef TOUCH_AUTOREPEAT_CLOCK_CONTROL_ASSERT_SVH
`define TOUCH_AUTOREPEAT_CLOCK_CONTROL_ASSERT_SVH
`ifndef SYNTHESIS
`define TACC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TACC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TACC_ASSERT(lbl, prop, msg)
`define TACC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/core/tacc_pkg.sv
// types, constants and helpers for the touch auto-repeat clock control block
package tacc_pkg;

	typedef enum logic [2:0] {
		ST_INIT     = 3'd0,
		ST_NEVER    = 3'd1,
		ST_WAIT     = 3'd2,
		ST_SETTLE   = 3'd3,
		ST_AUTO     = 3'd4,
		ST_RATE_RUN = 3'd5,
		ST_RATE_EXP = 3'd6,
		ST_SECOND   = 3'd7
	} ctrl_state_t;

	typedef enum logic [1:0] {
		CFG_AUTO_DELAY = 2'd0,
		CFG_REPEAT_RATE = 2'd1,
		CFG_TICKS_PER_SEC = 2'd2,
		CFG_UNUSED = 2'd3
	} cfg_index_t;

	localparam int unsigned CNT_W = 8;
	localparam logic [CNT_W-1:0] AUTO_DELAY_DEFAULT = 8'd9;
	localparam logic [CNT_W-1:0] REPEAT_RATE_DEFAULT = 8'd1;
	localparam logic [CNT_W-1:0] TICKS_PER_SEC_DEFAULT = 8'd19;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

### rtl/core/touch_autorepeat_clock_control.sv
// touch auto-repeat clock control: tick state machine with delay, rate and second counters
//
// Usage: every input beat on in_valid/in_ready is one timer tick carrying the
// sampled touch level; every tick gives exactly one result beat on
// out_valid/out_ready with adjust_pulse, second_pulse, clock_enabled and the
// state code after the tick.
// The tick is captured in an input register, the state update runs as
// logic from there into the result register: out_valid rises when the
// tick moves on into the result register, which waits while a full result
// stalls, and one tick is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds and the input register
// still takes one more tick; in_ready drops only when both are full.
// The config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; indexes 0..2 set auto delay, repeat rate and ticks per second,
// index 3 is ignored. Write it only while the block is idle.
// Reset (arst_n low) puts the machine in its initial state, clears the
// counters and loads the default limits 9, 1 and 19.
module touch_autorepeat_clock_control (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       touched,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       adjust_pulse,
	output logic       second_pulse,
	output logic       clock_enabled,
	output logic [2:0] state_code,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [tacc_pkg::CNT_W-1:0] auto_max_q, rate_max_q, sec_max_q;
	logic [tacc_pkg::CNT_W-1:0] delay_q, rate_q, subsec_q;
	logic [tacc_pkg::CNT_W-1:0] delay_d, rate_d, subsec_d;
	tacc_pkg::ctrl_state_t state_q, state_d;
	logic valid_s1, touched_s1;
	logic out_valid_q, adj_q, sec_q, en_q;
	logic adj_d, sec_d;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_max_q <= tacc_pkg::AUTO_DELAY_DEFAULT;
			rate_max_q <= tacc_pkg::REPEAT_RATE_DEFAULT;
			sec_max_q <= tacc_pkg::TICKS_PER_SEC_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tacc_pkg::cfg_index_t'(cfg_index))
				tacc_pkg::CFG_AUTO_DELAY: auto_max_q <= cfg_data;
				tacc_pkg::CFG_REPEAT_RATE: rate_max_q <= cfg_data;
				tacc_pkg::CFG_TICKS_PER_SEC: sec_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// counter action of the current state, then the transition
	always_comb begin
		delay_d = delay_q;
		rate_d = rate_q;
		subsec_d = subsec_q;
		state_d = state_q;
		adj_d = 1'b0;
		sec_d = 1'b0;
		unique case (state_q)
			tacc_pkg::ST_NEVER: begin
				delay_d = '0;
				rate_d = '0;
			end
			tacc_pkg::ST_WAIT: begin
				delay_d = '0;
				rate_d = '0;
				subsec_d = tacc_pkg::sat_inc(subsec_q);
			end
			tacc_pkg::ST_AUTO: delay_d = tacc_pkg::sat_inc(delay_q);
			tacc_pkg::ST_RATE_RUN: rate_d = tacc_pkg::sat_inc(rate_q);
			tacc_pkg::ST_RATE_EXP: rate_d = '0;
			tacc_pkg::ST_SECOND: subsec_d = '0;
			default: ;
		endcase
		unique case (state_q)
			tacc_pkg::ST_INIT: state_d = tacc_pkg::ST_NEVER;
			tacc_pkg::ST_NEVER: begin
				if (touched_s1) state_d = tacc_pkg::ST_SETTLE;
			end
			tacc_pkg::ST_WAIT: begin
				priority if (touched_s1) state_d = tacc_pkg::ST_SETTLE;
				else if (subsec_d >= sec_max_q) state_d = tacc_pkg::ST_SECOND;
				else state_d = tacc_pkg::ST_WAIT;
			end
			tacc_pkg::ST_SETTLE: begin
				if (!touched_s1) begin
					adj_d = 1'b1;
					state_d = tacc_pkg::ST_WAIT;
				end else begin
					state_d = tacc_pkg::ST_AUTO;
				end
			end
			tacc_pkg::ST_AUTO: begin
				if (touched_s1 && delay_d >= auto_max_q) begin
					adj_d = 1'b1;
					state_d = tacc_pkg::ST_RATE_RUN;
				end else if (!touched_s1) begin
					adj_d = 1'b1;
					state_d = tacc_pkg::ST_WAIT;
				end
			end
			tacc_pkg::ST_RATE_RUN: begin
				if (touched_s1 && rate_d >= rate_max_q)
					state_d = tacc_pkg::ST_RATE_EXP;
				else if (!touched_s1) state_d = tacc_pkg::ST_WAIT;
			end
			tacc_pkg::ST_RATE_EXP: begin
				if (touched_s1) begin
					adj_d = 1'b1;
					state_d = tacc_pkg::ST_RATE_RUN;
				end else begin
					state_d = tacc_pkg::ST_WAIT;
				end
			end
			tacc_pkg::ST_SECOND: begin
				sec_d = 1'b1;
				state_d = tacc_pkg::ST_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q <= tacc_pkg::ST_INIT;
			delay_q <= '0;
			rate_q <= '0;
			subsec_q <= '0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q <= state_d;
				delay_q <= delay_d;
				rate_q <= rate_d;
				subsec_q <= subsec_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) touched_s1 <= touched;
		if (advance) begin
			adj_q <= adj_d;
			sec_q <= sec_d;
			en_q <= (state_d >= tacc_pkg::ST_WAIT);
		end
	end

	assign out_valid = out_valid_q;
	assign adjust_pulse = adj_q;
	assign second_pulse = sec_q;
	assign clock_enabled = en_q;
	assign state_code = state_q;

`include "touch_autorepeat_clock_control_assert.svh"

	`TACC_ASSERT(a_adv_fills_out, advance |=> out_valid_q, "result beat lost after advance")
	`TACC_ASSERT(a_left_init, advance |=> state_q != tacc_pkg::ST_INIT, "state stuck in init")
	`TACC_ASSERT(a_sec_wait, out_valid_q && sec_q |-> state_q == tacc_pkg::ST_WAIT, "stray second")
	`TACC_ASSERT_ALWAYS(a_no_room, !in_ready |-> valid_s1 && out_valid_q && !out_ready, "early stall")

endmodule

### dv/tb_top.sv
// self-checking testbench for the touch auto-repeat clock control block
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                  adjust;
		logic                  second;
		logic                  enabled;
		tacc_pkg::ctrl_state_t state;
	} tick_outcome_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       touched = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       adjust_pulse;
	logic       second_pulse;
	logic       clock_enabled;
	logic [2:0] state_code;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = tacc_pkg::CFG_AUTO_DELAY;
	logic [7:0] cfg_data = 8'd0;

	// shadow of the block's limits and state
	logic [7:0]  delay_limit = tacc_pkg::AUTO_DELAY_DEFAULT;
	logic [7:0]  rate_limit = tacc_pkg::REPEAT_RATE_DEFAULT;
	logic [7:0]  second_limit = tacc_pkg::TICKS_PER_SEC_DEFAULT;
	tacc_pkg::ctrl_state_t ctl_state = tacc_pkg::ST_INIT;
	logic [7:0]  hold_cnt = 8'd0;
	logic [7:0]  repeat_cnt = 8'd0;
	logic [7:0]  idle_cnt = 8'd0;

	tick_outcome_t due_outcomes[$];
	tick_outcome_t head;

	int gap_pct = 0;
	int stall_pct = 0;
	int ticks_sent = 0;
	int beats_checked = 0;
	int adjust_seen = 0;
	int second_seen = 0;
	int reg_writes = 0;
	int mismatches = 0;

	touch_autorepeat_clock_control u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.touched      (touched),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.adjust_pulse (adjust_pulse),
		.second_pulse (second_pulse),
		.clock_enabled(clock_enabled),
		.state_code   (state_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("touch_autorepeat_clock_control regression: fail");
		$finish;
	end

	function automatic logic [7:0] count_up(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic tick_outcome_t advance_tick(input logic level);
		tacc_pkg::ctrl_state_t cur;
		tacc_pkg::ctrl_state_t nxt;
		tick_outcome_t         r;
		cur = ctl_state;
		nxt = cur;
		r = '0;
		case (cur)
			tacc_pkg::ST_NEVER: begin
				hold_cnt = 8'd0;
				repeat_cnt = 8'd0;
			end
			tacc_pkg::ST_WAIT: begin
				hold_cnt = 8'd0;
				repeat_cnt = 8'd0;
				idle_cnt = count_up(idle_cnt);
			end
			tacc_pkg::ST_AUTO: hold_cnt = count_up(hold_cnt);
			tacc_pkg::ST_RATE_RUN: repeat_cnt = count_up(repeat_cnt);
			tacc_pkg::ST_RATE_EXP: repeat_cnt = 8'd0;
			tacc_pkg::ST_SECOND: idle_cnt = 8'd0;
			default: ;
		endcase
		case (cur)
			tacc_pkg::ST_INIT: nxt = tacc_pkg::ST_NEVER;
			tacc_pkg::ST_NEVER: if (level) nxt = tacc_pkg::ST_SETTLE;
			tacc_pkg::ST_WAIT: begin
				if (idle_cnt >= second_limit) nxt = tacc_pkg::ST_SECOND;
				// touch wins over a due second
				if (level) nxt = tacc_pkg::ST_SETTLE;
			end
			tacc_pkg::ST_SETTLE: begin
				if (!level) begin
					r.adjust = 1'b1;
					nxt = tacc_pkg::ST_WAIT;
				end else begin
					nxt = tacc_pkg::ST_AUTO;
				end
			end
			tacc_pkg::ST_AUTO: begin
				if (level && hold_cnt >= delay_limit) begin
					r.adjust = 1'b1;
					nxt = tacc_pkg::ST_RATE_RUN;
				end else if (!level) begin
					r.adjust = 1'b1;
					nxt = tacc_pkg::ST_WAIT;
				end
			end
			tacc_pkg::ST_RATE_RUN: begin
				if (level && repeat_cnt >= rate_limit) nxt = tacc_pkg::ST_RATE_EXP;
				else if (!level) nxt = tacc_pkg::ST_WAIT;
			end
			tacc_pkg::ST_RATE_EXP: begin
				if (level) begin
					r.adjust = 1'b1;
					nxt = tacc_pkg::ST_RATE_RUN;
				end else begin
					nxt = tacc_pkg::ST_WAIT;
				end
			end
			tacc_pkg::ST_SECOND: begin
				r.second = 1'b1;
				nxt = tacc_pkg::ST_WAIT;
			end
			default: nxt = tacc_pkg::ST_WAIT;
		endcase
		ctl_state = nxt;
		r.state = nxt;
		r.enabled = (nxt != tacc_pkg::ST_INIT) && (nxt != tacc_pkg::ST_NEVER);
		return r;
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_outcomes.size() == 0) begin
				$error("result beat with no tick outstanding");
				mismatches++;
			end else begin
				head = due_outcomes.pop_front();
				beats_checked++;
				if (adjust_pulse) adjust_seen++;
				if (second_pulse) second_seen++;
				if (adjust_pulse !== head.adjust) begin
					$error("adjust_pulse expected %0b got %0b", head.adjust, adjust_pulse);
					mismatches++;
				end
				if (second_pulse !== head.second) begin
					$error("second_pulse expected %0b got %0b", head.second, second_pulse);
					mismatches++;
				end
				if (clock_enabled !== head.enabled) begin
					$error("clock_enabled expected %0b got %0b", head.enabled, clock_enabled);
					mismatches++;
				end
				if (state_code !== head.state) begin
					$error("state_code expected %0d got %0d", head.state, state_code);
					mismatches++;
				end
			end
		end
	end

	task automatic send_tick(input logic level);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		touched <= level;
		do @(posedge clk); while (!in_ready);
		due_outcomes.push_back(advance_tick(level));
		ticks_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input tacc_pkg::cfg_index_t idx, input logic [7:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			tacc_pkg::CFG_AUTO_DELAY: delay_limit = val;
			tacc_pkg::CFG_REPEAT_RATE: rate_limit = val;
			tacc_pkg::CFG_TICKS_PER_SEC: second_limit = val;
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [7:0] dly, input logic [7:0] rate,
			input logic [7:0] sec);
		write_reg(tacc_pkg::CFG_AUTO_DELAY, dly);
		write_reg(tacc_pkg::CFG_REPEAT_RATE, rate);
		write_reg(tacc_pkg::CFG_TICKS_PER_SEC, sec);
	endtask

	task automatic set_small_limits();
		set_limits(8'($urandom_range(0, 12)), 8'($urandom_range(0, 6)),
			8'($urandom_range(0, 20)));
	endtask

	task automatic run_touch_mix(input int n, input int hold_max, input int gap_max);
		int stop_at;
		stop_at = ticks_sent + n;
		while (ticks_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat ($urandom_range(1, 2)) send_tick(1'b1);
					repeat ($urandom_range(1, 3)) send_tick(1'b0);
				end
				3, 4, 5: begin
					repeat ($urandom_range(1, hold_max)) send_tick(1'b1);
					send_tick(1'b0);
				end
				6, 7: repeat ($urandom_range(1, gap_max)) send_tick(1'b0);
				8: repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
				default: begin
					if ($urandom_range(0, 3) == 0) wait_drained();
					else send_tick(1'b1);
				end
			endcase
		end
	endtask

	task automatic test_startup_and_tap();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	task automatic test_zero_limits();
		set_limits(8'd0, 8'd0, 8'd0);
		// unused index must leave the limits alone
		write_reg(tacc_pkg::CFG_UNUSED, 8'hFF);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		repeat (6) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	task automatic test_max_limits();
		set_limits(8'hFF, 8'hFF, 8'hFF);
		repeat (3) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	task automatic test_subsecond_saturation();
		write_reg(tacc_pkg::CFG_TICKS_PER_SEC, 8'hFF);
		while (ctl_state != tacc_pkg::ST_WAIT) send_tick(ctl_state == tacc_pkg::ST_NEVER);
		while (idle_cnt < 8'd254) send_tick(1'b0);
		// taps keep the count pinned at the top
		repeat (6) begin
			send_tick(1'b1);
			send_tick(1'b0);
		end
		repeat (3) send_tick(1'b0);
	endtask

	task automatic test_random_defaults();
		gap_pct = 0;
		stall_pct = 0;
		set_limits(tacc_pkg::AUTO_DELAY_DEFAULT, tacc_pkg::REPEAT_RATE_DEFAULT,
			tacc_pkg::TICKS_PER_SEC_DEFAULT);
		run_touch_mix(220, 30, 30);
	endtask

	task automatic test_random_sender_idle();
		gap_pct = 59;
		stall_pct = 0;
		set_small_limits();
		run_touch_mix(95, 16, 22);
		set_small_limits();
		run_touch_mix(95, 16, 22);
	endtask

	task automatic test_random_receiver_stall();
		gap_pct = 0;
		stall_pct = 59;
		set_small_limits();
		run_touch_mix(95, 16, 22);
		wait_drained();
		run_touch_mix(95, 16, 22);
	endtask

	task automatic test_random_both_idle();
		gap_pct = 21;
		stall_pct = 21;
		set_small_limits();
		run_touch_mix(95, 16, 22);
		set_limits(8'd40, 8'd20, 8'd60);
		run_touch_mix(95, 60, 70);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_startup_and_tap();
		test_zero_limits();
		test_max_limits();
		test_subsecond_saturation();
		test_random_defaults();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();
		gap_pct = 0;
		stall_pct = 0;
		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d ticks, %0d result beats (%0d adjust, %0d second pulses)",
			ticks_sent, beats_checked, adjust_seen, second_seen);
		$display("%0d register writes across default, zero, full-scale and random limits",
			reg_writes);
		if (mismatches == 0 && due_outcomes.size() == 0) begin
			$display("touch_autorepeat_clock_control regression: pass");
		end else begin
			$display("touch_autorepeat_clock_control regression: fail");
		end
		$finish;
	end

endmodule
